[src/c3f_pkg.sv]
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types, register indexes and geometry constants of the 3x3 filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

    localparam int MaxWidth   = 256;
    localparam int ColW       = 8;
    localparam int RowW       = 12;
    localparam int MaxHeight  = 4095;
    localparam int SumW       = 20;

    localparam logic [2:0] REG_COEF_TOP    = 3'd0;
    localparam logic [2:0] REG_COEF_MID    = 3'd1;
    localparam logic [2:0] REG_COEF_BOTTOM = 3'd2;
    localparam logic [2:0] REG_DIVISOR     = 3'd3;
    localparam logic [2:0] REG_BIAS        = 3'd4;
    localparam logic [2:0] REG_WIDTH       = 3'd5;
    localparam logic [2:0] REG_HEIGHT      = 3'd6;

    typedef struct packed {
        logic [23:0] coef_top;
        logic [23:0] coef_mid;
        logic [23:0] coef_bot;
        logic [7:0]  divisor;
        logic [7:0]  bias;
    } filt_cfg_t;

    // window produced by the line store, with its position
    typedef struct packed {
        logic [71:0]     pix;   // row-major: top l,c,r, mid l,c,r, bot l,c,r
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic            eof;
    } win_t;

    typedef struct packed {
        logic [7:0]      pixel;
        logic [RowW-1:0] row;
        logic [ColW-1:0] col;
        logic            eof;
        logic            fault;
    } res_t;

endpackage

[src/c3f_line_store.sv]
// ----------------------------------------------------------------------------
// c3f_line_store
// Two line memories and the window shift registers; one pixel per transfer.
// ----------------------------------------------------------------------------
module c3f_line_store (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             pixel_in,
    input  logic                   frame_start,
    input  logic [8:0]             frame_width,
    input  logic [11:0]            frame_height,
    output logic                   win_valid,
    input  logic                   win_ready,
    output c3f_pkg::win_t          win
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [7:0] line_prev  [c3f_pkg::MaxWidth];
    logic [7:0] line_prev2 [c3f_pkg::MaxWidth];

    logic [1:0]  state_reg, state_next;
    logic [8:0]  col_reg;
    logic [11:0] row_reg;
    logic [7:0]  win_reg [6];
    logic [7:0]  pix_reg;
    logic [7:0]  addr_reg;
    logic [11:0] r_reg;
    logic [7:0]  top_q, mid_q;
    logic        emit_reg;
    c3f_pkg::win_t win_reg_o;

    logic [8:0]  w_c;
    logic [11:0] h_c;
    logic [8:0]  c_n;
    logic [11:0] r_n;
    logic        take;

    always_comb begin
        w_c = frame_width;
        if (w_c < 9'd3) w_c = 9'd3;
        if (w_c > 9'(c3f_pkg::MaxWidth)) w_c = 9'(c3f_pkg::MaxWidth);
        h_c = frame_height;
        if (h_c < 12'd3) h_c = 12'd3;
        if (h_c == 12'hFFF) h_c = 12'(c3f_pkg::MaxHeight);
        if (frame_start) begin
            c_n = '0;
            r_n = '0;
        end else begin
            c_n = col_reg;
            r_n = row_reg;
            if (c_n >= w_c) begin
                c_n = '0;
                r_n = r_n + 12'd1;
            end
            if (r_n >= h_c) r_n = '0;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    assign win_valid = (state_reg == ST_OUT);
    assign win       = win_reg_o;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take) state_next = ST_READ;
            ST_READ: state_next = emit_reg ? ST_OUT : ST_IDLE;
            ST_OUT:  if (win_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // read the column, then write back shifted values next cycle
    always_ff @(posedge aclk) begin
        if (take) begin
            top_q <= line_prev2[c_n[7:0]];
            mid_q <= line_prev[c_n[7:0]];
        end
        if (state_reg == ST_READ) begin
            line_prev2[addr_reg] <= mid_q;
            line_prev[addr_reg]  <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pix_reg  <= pixel_in;
            addr_reg <= c_n[7:0];
            r_reg    <= r_n;
        end
        if (state_reg == ST_READ) begin
            win_reg_o.pix <= {win_reg[0], win_reg[3], top_q,
                              win_reg[1], win_reg[4], mid_q,
                              win_reg[2], win_reg[5], pix_reg};
            win_reg_o.row <= r_reg - 12'd1;
            win_reg_o.col <= addr_reg - 8'd1;
            win_reg_o.eof <= (r_reg == h_c - 12'd1) && ({1'b0, addr_reg} == w_c - 9'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            emit_reg  <= 1'b0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                col_reg  <= c_n + 9'd1;
                row_reg  <= r_n;
                emit_reg <= (r_n >= 12'd2) && (c_n >= 9'd2);
            end
            if (state_reg == ST_READ) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_q;
                win_reg[4] <= mid_q;
                win_reg[5] <= pix_reg;
            end
        end
    end

endmodule

[src/c3f_compute.sv]
// ----------------------------------------------------------------------------
// c3f_compute
// Weighted sum, iterative signed division, bias and output register.
// ----------------------------------------------------------------------------
module c3f_compute (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                win_valid,
    output logic                win_ready,
    input  c3f_pkg::win_t       win,
    input  c3f_pkg::filt_cfg_t  cfg,
    output logic                res_valid,
    input  logic                res_ready,
    output c3f_pkg::res_t       res
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAC  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
    localparam logic [2:0] ST_BIAS = 3'd5;

    localparam int SW = c3f_pkg::SumW;

    logic [2:0]    state_reg;
    logic [4:0]    cnt_reg;
    logic [71:0]   pix_reg;
    logic [71:0]   coef_reg;
    logic signed [SW-1:0] acc_reg;
    logic [SW-1:0] quo_reg;
    logic [7:0]    rem_reg;
    logic [SW-1:0] mag_reg;
    logic [7:0]    dmag;
    logic          neg_reg;
    c3f_pkg::res_t res_reg;

    logic signed [8:0]  w_s;
    logic signed [16:0] prod;
    logic signed [7:0]  d_s;
    logic [8:0]         trial;
    logic [7:0]         rem_sh;
    logic signed [SW-1:0] q_s;
    logic signed [SW-1:0] val;

    assign d_s   = $signed(cfg.divisor);
    assign dmag  = d_s[7] ? 8'(-d_s) : {1'b0, d_s[6:0]};
    assign w_s   = 9'(signed'(coef_reg[7:0]));
    assign prod  = w_s * $signed({1'b0, pix_reg[7:0]});
    assign rem_sh = {rem_reg[6:0], mag_reg[SW-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, dmag};
    assign q_s   = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign val   = ((d_s == 8'sd0) ? '0 : q_s) + SW'(signed'(cfg.bias));

    assign win_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (win_valid) begin
                    // order: bottom row right..left first since pix is top-first msb
                    pix_reg  <= {win.pix[71:64], win.pix[63:56], win.pix[55:48],
                                 win.pix[47:40], win.pix[39:32], win.pix[31:24],
                                 win.pix[23:16], win.pix[15:8], win.pix[7:0]};
                    coef_reg <= {cfg.coef_top[7:0], cfg.coef_top[15:8], cfg.coef_top[23:16],
                                 cfg.coef_mid[7:0], cfg.coef_mid[15:8], cfg.coef_mid[23:16],
                                 cfg.coef_bot[7:0], cfg.coef_bot[15:8], cfg.coef_bot[23:16]};
                    acc_reg  <= '0;
                    cnt_reg  <= '0;
                    res_reg.row <= win.row;
                    res_reg.col <= win.col;
                    res_reg.eof <= win.eof;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    acc_reg  <= acc_reg + SW'(prod);
                    pix_reg  <= pix_reg >> 8;
                    coef_reg <= coef_reg >> 8;
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd8) state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    neg_reg <= acc_reg[SW-1] ^ d_s[7];
                    mag_reg <= acc_reg[SW-1] ? SW'(-acc_reg) : SW'(acc_reg);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    mag_reg <= mag_reg << 1;
                    if (!trial[8]) begin
                        rem_reg <= trial[7:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(SW - 1)) state_reg <= ST_BIAS;
                end
                ST_BIAS: begin
                    // capture final value once the last quotient bit has landed
                    res_reg.pixel <= val[7:0];
                    res_reg.fault <= (d_s == 8'sd0);
                    state_reg <= ST_OUT;
                end
                ST_OUT: if (res_ready) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[src/conv3x3_image_filter.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster pixel stream with configurable weights.
// ----------------------------------------------------------------------------
// channel   dir  tdata bits                         tuser
// s_axis    in   [7:0] pixel_in                     [0] frame_start
// m_axis    out  [7:0] pixel_out [19:8] out_row     [0] divide_fault
//                [27:20] out_col, tlast end_of_frame
// cfg       in   cfg_index [2:0], cfg_data [23:0]
// Each pixel passes through the line store (read, write back); an
// interior pixel then holds the shared unit through its steps: load,
// multiply-accumulate, sign, division, bias and output.
// Sync reset clears position and window; line memories are not cleared.
// Either side may stall at any time; a held result blocks the input.
// ----------------------------------------------------------------------------
module conv3x3_image_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // pixel_in
    input  logic        s_axis_tuser,   // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // pixel_out, out_row, out_col, zero pad
    output logic        m_axis_tlast,   // end_of_frame
    output logic        m_axis_tuser,   // divide_fault
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    c3f_pkg::filt_cfg_t cfg_reg;
    logic [8:0]  width_reg;
    logic [11:0] height_reg;
    logic        win_valid, win_ready;
    c3f_pkg::win_t win;
    c3f_pkg::res_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_top <= 24'h020202;
            cfg_reg.coef_mid <= 24'h020202;
            cfg_reg.coef_bot <= 24'h020202;
            cfg_reg.divisor  <= 8'd18;
            cfg_reg.bias     <= 8'hFF;
            width_reg        <= 9'd200;
            height_reg       <= 12'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                c3f_pkg::REG_COEF_TOP:    cfg_reg.coef_top <= cfg_data;
                c3f_pkg::REG_COEF_MID:    cfg_reg.coef_mid <= cfg_data;
                c3f_pkg::REG_COEF_BOTTOM: cfg_reg.coef_bot <= cfg_data;
                c3f_pkg::REG_DIVISOR:     cfg_reg.divisor  <= cfg_data[7:0];
                c3f_pkg::REG_BIAS:        cfg_reg.bias     <= cfg_data[7:0];
                c3f_pkg::REG_WIDTH:       width_reg        <= cfg_data[8:0];
                c3f_pkg::REG_HEIGHT:      height_reg       <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    c3f_line_store u_line (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .pixel_in(s_axis_tdata), .frame_start(s_axis_tuser),
        .frame_width(width_reg), .frame_height(height_reg),
        .win_valid, .win_ready, .win
    );

    c3f_compute u_comp (
        .aclk, .aresetn,
        .win_valid, .win_ready, .win, .cfg(cfg_reg),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
    );

    assign m_axis_tdata = {4'b0, res.col, res.row, res.pixel};
    assign m_axis_tlast = res.eof;
    assign m_axis_tuser = res.fault;

endmodule

[src/c3f_checker.sv]
// ----------------------------------------------------------------------------
// c3f_port_assert
// Port-level checks of the 3x3 filter.
// ----------------------------------------------------------------------------
module c3f_port_assert (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[31:28] == 4'b0)
        else $error("pad bits set");

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[27:20] != 8'd0 && m_axis_tdata[19:8] != 12'd0)
        else $error("border position in result");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

endmodule

bind conv3x3_image_filter c3f_port_assert u_c3f_port_assert (
    .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

[dv/c3f_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3f_checker
// Watches the pixel, result and register channels of the 3x3 filter, computes
// the filtered value and position of each interior window on its own copy of
// the line stores and weights, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module c3f_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        m_axis_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    logic [23:0] wt_top, wt_mid, wt_bot;
    logic [7:0]  div_reg, bias_reg;
    logic [8:0]  width_reg;
    logic [11:0] height_reg;
    logic [7:0]  row1_mem [c3f_pkg::MaxWidth];
    logic [7:0]  row2_mem [c3f_pkg::MaxWidth];
    logic [7:0]  win_hist [6];
    int          next_col, next_row;
    c3f_pkg::res_t filtered_q [$];

    assign pending_count = filtered_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int tap(input logic [23:0] rw, input int pos);
        return int'($signed(rw[8*pos +: 8]));
    endfunction

    task automatic filter_pixel(input logic [7:0] p, input logic fs);
        int   w, h, c, r, sum, d, val;
        int   win [3][3];
        logic [7:0] top, mid;
        c3f_pkg::res_t rs;
        w = width_reg; h = height_reg;
        if (w < 3) w = 3;
        if (w > c3f_pkg::MaxWidth) w = c3f_pkg::MaxWidth;
        if (h < 3) h = 3;
        if (h > c3f_pkg::MaxHeight) h = c3f_pkg::MaxHeight;
        if (fs) begin
            c = 0; r = 0;
        end else begin
            c = next_col; r = next_row;
            if (c >= w) begin
                c = 0; r++;
            end
            if (r >= h) r = 0;
        end
        top = row2_mem[c]; mid = row1_mem[c];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win_hist[i];
            win[i][1] = win_hist[3+i];
        end
        win[0][2] = top; win[1][2] = mid; win[2][2] = p;
        row2_mem[c] = mid; row1_mem[c] = p;
        for (int i = 0; i < 3; i++) win_hist[i] = win_hist[3+i];
        win_hist[3] = top; win_hist[4] = mid; win_hist[5] = p;
        next_col = c + 1; next_row = r;
        if (r < 2 || c < 2) return;
        sum = 0;
        for (int j = 0; j < 3; j++)
            sum += tap(wt_top, j) * win[0][j] + tap(wt_mid, j) * win[1][j]
                 + tap(wt_bot, j) * win[2][j];
        d = int'($signed(div_reg));
        val = (d == 0) ? 0 : sum / d;
        val += int'($signed(bias_reg));
        rs.pixel = val[7:0];
        rs.row   = 12'(r - 1);
        rs.col   = 8'(c - 1);
        rs.eof   = (r == h - 1) && (c == w - 1);
        rs.fault = (d == 0);
        filtered_q.push_back(rs);
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        c3f_pkg::res_t want;
        if (!aresetn) begin
            wt_top = 24'h020202; wt_mid = 24'h020202; wt_bot = 24'h020202;
            div_reg = 8'd18; bias_reg = 8'hFF;
            width_reg = 9'd200; height_reg = 12'd200;
            for (int i = 0; i < 6; i++) win_hist[i] = '0;
            next_col = 0; next_row = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    c3f_pkg::REG_COEF_TOP:    wt_top     = cfg_data;
                    c3f_pkg::REG_COEF_MID:    wt_mid     = cfg_data;
                    c3f_pkg::REG_COEF_BOTTOM: wt_bot     = cfg_data;
                    c3f_pkg::REG_DIVISOR:     div_reg    = cfg_data[7:0];
                    c3f_pkg::REG_BIAS:        bias_reg   = cfg_data[7:0];
                    c3f_pkg::REG_WIDTH:       width_reg  = cfg_data[8:0];
                    c3f_pkg::REG_HEIGHT:      height_reg = cfg_data[11:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) filter_pixel(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (filtered_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = filtered_q.pop_front();
                    if (m_axis_tdata[7:0] != want.pixel)
                        report_mismatch("pixel_out", m_axis_tdata[7:0], want.pixel);
                    if (m_axis_tdata[19:8] != want.row)
                        report_mismatch("out_row", m_axis_tdata[19:8], want.row);
                    if (m_axis_tdata[27:20] != want.col)
                        report_mismatch("out_col", m_axis_tdata[27:20], want.col);
                    if (m_axis_tlast != want.eof)
                        report_mismatch("end_of_frame", m_axis_tlast, want.eof);
                    if (m_axis_tuser != want.fault)
                        report_mismatch("divide_fault", m_axis_tuser, want.fault);
                end
            end
        end
    end

endmodule

[dv/tb_conv3x3_image_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_image_filter
// Streams whole small frames through the 3x3 filter under several weight,
// divisor, bias and size settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_conv3x3_image_filter;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid, s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast, m_axis_tuser;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    int          fail_count, pending_count;
    bit          steady_mode;   // no idling on either side
    bit          hold_sink;     // long receiver hold-off
    int          pixels_sent;

    conv3x3_image_filter DUT (.*);

    c3f_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, a long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else if (hold_sink) m_axis_tready <= 1'b0;
        else m_axis_tready <= steady_mode || ($urandom_range(99) >= 34);
    end

    initial begin
        int n;
        n = 0;
        hold_sink <= 1'b0;
        @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (pixels_sent > 60 && n == 0) begin
                hold_sink <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_sink <= 1'b0;
                n = 1;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] p, input logic fs);
        while (!steady_mode && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1; s_axis_tdata <= p; s_axis_tuser <= fs;
        do @(posedge aclk); while (!s_axis_tready);
        pixels_sent++;
    endtask

    // one frame of w x h pixels; kind picks the pixel pattern
    task automatic send_frame(input int w, input int h, input int kind);
        logic [7:0] p;
        for (int i = 0; i < w * h; i++) begin
            case (kind)
                0: p = 8'hFF;
                1: p = 8'h00;
                2: p = (i % 2) ? 8'hFF : 8'h00;
                default: p = 8'($urandom);
            endcase
            send_pixel(p, i == 0);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic settle;
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_geometry(input int w, input int h);
        write_reg(c3f_pkg::REG_WIDTH, 24'(w));
        write_reg(c3f_pkg::REG_HEIGHT, 24'(h));
    endtask

    initial begin
        int w, h, nf;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        steady_mode = 1'b0; pixels_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: reset weights, extreme pixels, then extreme weights
        set_geometry(3, 3);
        send_frame(3, 3, 0);
        settle();
        write_reg(c3f_pkg::REG_COEF_TOP, 24'h7F7F7F);
        write_reg(c3f_pkg::REG_COEF_MID, 24'h7F7F7F);
        write_reg(c3f_pkg::REG_COEF_BOTTOM, 24'h7F7F7F);
        write_reg(c3f_pkg::REG_DIVISOR, 24'h000001);
        write_reg(c3f_pkg::REG_BIAS, 24'h00007F);
        send_frame(3, 3, 0);
        settle();
        write_reg(c3f_pkg::REG_COEF_TOP, 24'h808080);
        write_reg(c3f_pkg::REG_COEF_MID, 24'h80FF80);
        write_reg(c3f_pkg::REG_COEF_BOTTOM, 24'h808080);
        write_reg(c3f_pkg::REG_DIVISOR, 24'h0000C0);
        write_reg(c3f_pkg::REG_BIAS, 24'h000080);
        set_geometry(4, 3);
        send_frame(4, 3, 2);
        settle();
        // zero divisor gives the bias and raises the fault
        write_reg(c3f_pkg::REG_DIVISOR, 24'h000000);
        send_frame(4, 3, 3);
        settle();
        // out-of-range size clamps to 3x3; frames wrap without a start flag
        set_geometry(0, 0);
        for (int i = 0; i < 18; i++) send_pixel(8'($urandom), i == 0);
        s_axis_tvalid <= 1'b0;
        settle();
        // random settings and frames
        for (int ph = 0; ph < 9; ph++) begin
            write_reg(c3f_pkg::REG_COEF_TOP, 24'($urandom));
            write_reg(c3f_pkg::REG_COEF_MID, 24'($urandom));
            write_reg(c3f_pkg::REG_COEF_BOTTOM, 24'($urandom));
            write_reg(c3f_pkg::REG_DIVISOR,
                      (ph == 4) ? 24'h000040 : 24'($urandom_range(128) - 64));
            write_reg(c3f_pkg::REG_BIAS, 24'($urandom));
            w = (ph == 7) ? 64 : $urandom_range(3, 8);
            h = (ph == 7) ? 3 : $urandom_range(3, 7);
            nf = (ph == 7) ? 1 : 2;
            set_geometry(w, h);
            steady_mode = (ph == 5);
            for (int f = 0; f < nf; f++) send_frame(w, h, 3);
            steady_mode = 1'b0;
            settle();
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
